// ===== sv/tabs_pkg.sv =====
// Package for the two-axis Bresenham stepper: operation and status codes,
// reset values of the configuration registers and the result beat layout.
// No dependencies.
package tabs_pkg;

  localparam int unsigned StepCountBitsDef = 23;
  localparam int unsigned PositionBitsDef  = 32;

  localparam int unsigned IntervalBits = 20;
  localparam int unsigned TimeoutBits  = 25;
  localparam int unsigned StepInBits   = 24;
  localparam int unsigned PosOutBits   = 32;
  localparam int unsigned CfgDataBits  = 25;
  localparam int unsigned CfgIdxBits   = 2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] CFG_MIN_INTERVAL     = 2'd0;
  localparam logic [1:0] CFG_MAX_INTERVAL     = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd3;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT  = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic [IntervalBits-1:0] MinIntervalRst     = 20'd100;
  localparam logic [IntervalBits-1:0] MaxIntervalRst     = 20'd1000000;
  localparam logic [IntervalBits-1:0] DefaultIntervalRst = 20'd500;
  localparam logic [TimeoutBits-1:0]  TimeoutTicksRst    = 25'd30000000;

  typedef struct packed {
    logic                    theta_fwd;
    logic                    rho_fwd;
    logic                    empty;
    logic [IntervalBits-1:0] interval;
  } start_info_t;

  // Packed so that the first field sits in the highest bits.
  typedef struct packed {
    logic [2:0]            status;
    logic                  busy_res;
    logic [PosOutBits-1:0] rho_position;
    logic [PosOutBits-1:0] theta_position;
    logic                  rho_direction;
    logic                  theta_direction;
    logic                  rho_pulse;
    logic                  theta_pulse;
  } result_t;

endpackage

// ===== sv/tabs_start.sv =====
// Start decode: step magnitudes with saturation, directions and the clamped
// step interval. Depends on tabs_pkg.
module tabs_start
  import tabs_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef
) (
  input  logic [StepInBits-1:0]      theta_cnt_i,
  input  logic [StepInBits-1:0]      rho_cnt_i,
  input  logic [IntervalBits-1:0]    step_interval_i,
  input  logic [IntervalBits-1:0]    min_interval_i,
  input  logic [IntervalBits-1:0]    max_interval_i,
  input  logic [IntervalBits-1:0]    default_interval_i,
  output logic [STEP_COUNT_BITS-1:0] theta_mag_o,
  output logic [STEP_COUNT_BITS-1:0] rho_mag_o,
  output start_info_t                info_o
);

  logic [StepInBits-1:0]   theta_abs;
  logic [StepInBits-1:0]   rho_abs;
  logic [IntervalBits-1:0] iv_dflt;
  logic [IntervalBits-1:0] iv_max;
  logic [IntervalBits-1:0] iv_min;

  assign theta_abs = theta_cnt_i[StepInBits-1] ? StepInBits'(-theta_cnt_i) : theta_cnt_i;
  assign rho_abs   = rho_cnt_i[StepInBits-1]   ? StepInBits'(-rho_cnt_i)   : rho_cnt_i;

  if (STEP_COUNT_BITS < StepInBits) begin : g_sat
    assign theta_mag_o = (|theta_abs[StepInBits-1:STEP_COUNT_BITS]) ? '1 :
                         theta_abs[STEP_COUNT_BITS-1:0];
    assign rho_mag_o   = (|rho_abs[StepInBits-1:STEP_COUNT_BITS]) ? '1 :
                         rho_abs[STEP_COUNT_BITS-1:0];
  end else begin : g_nosat
    assign theta_mag_o = STEP_COUNT_BITS'(theta_abs);
    assign rho_mag_o   = STEP_COUNT_BITS'(rho_abs);
  end

  assign iv_dflt = (step_interval_i == '0) ? default_interval_i : step_interval_i;
  assign iv_max  = (iv_dflt > max_interval_i) ? max_interval_i : iv_dflt;
  assign iv_min  = (iv_max < min_interval_i) ? min_interval_i : iv_max;

  assign info_o.theta_fwd = ~theta_cnt_i[StepInBits-1];
  assign info_o.rho_fwd   = ~rho_cnt_i[StepInBits-1];
  assign info_o.empty     = (theta_cnt_i == '0) && (rho_cnt_i == '0);
  assign info_o.interval  = (iv_min == '0) ? IntervalBits'(1) : iv_min;

endmodule

// ===== sv/tabs_core.sv =====
// Move state and per-beat update: interval counter, Bresenham error term,
// steps left, positions and timeout. Depends on tabs_pkg.
module tabs_core
  import tabs_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef,
  parameter int unsigned POSITION_BITS   = PositionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [1:0]                 op_i,
  input  logic [STEP_COUNT_BITS-1:0] theta_mag_i,
  input  logic [STEP_COUNT_BITS-1:0] rho_mag_i,
  input  start_info_t                info_i,
  input  logic [TimeoutBits-1:0]     timeout_ticks_i,
  output result_t                    res_o
);

  localparam int unsigned EW = STEP_COUNT_BITS + 2;

  logic [IntervalBits-1:0]        interval_count_q, interval_count_d;
  logic [IntervalBits-1:0]        interval_value_q, interval_value_d;
  logic [TimeoutBits-1:0]         elapsed_q, elapsed_d;
  logic [STEP_COUNT_BITS-1:0]     theta_total_q, theta_total_d;
  logic [STEP_COUNT_BITS-1:0]     rho_total_q, rho_total_d;
  logic [STEP_COUNT_BITS-1:0]     theta_left_q, theta_left_d;
  logic [STEP_COUNT_BITS-1:0]     rho_left_q, rho_left_d;
  logic signed [EW-1:0]           error_q, error_d;
  logic                           theta_major_q, theta_major_d;
  logic                           theta_sign_q, theta_sign_d;
  logic                           rho_sign_q, rho_sign_d;
  logic                           running_q, running_d;
  logic [POSITION_BITS-1:0]       theta_pos_q, theta_pos_d;
  logic [POSITION_BITS-1:0]       rho_pos_q, rho_pos_d;

  logic signed [EW-1:0]     theta_e, rho_e, err_sub, err_add;
  logic [IntervalBits-1:0]  count_inc;
  logic                     alarm, st, sr, tp, rp;
  logic [2:0]               status;

  assign theta_e   = $signed({2'b00, theta_total_q});
  assign rho_e     = $signed({2'b00, rho_total_q});
  assign err_sub   = error_q - rho_e;
  assign err_add   = error_q + theta_e;
  assign count_inc = interval_count_q + IntervalBits'(1);
  assign alarm     = count_inc >= interval_value_q;

  always_comb begin
    interval_count_d = interval_count_q;
    interval_value_d = interval_value_q;
    elapsed_d        = elapsed_q;
    theta_total_d    = theta_total_q;
    rho_total_d      = rho_total_q;
    theta_left_d     = theta_left_q;
    rho_left_d       = rho_left_q;
    error_d          = error_q;
    theta_major_d    = theta_major_q;
    theta_sign_d     = theta_sign_q;
    rho_sign_d       = rho_sign_q;
    running_d        = running_q;
    theta_pos_d      = theta_pos_q;
    rho_pos_d        = rho_pos_q;
    st               = 1'b0;
    sr               = 1'b0;
    tp               = 1'b0;
    rp               = 1'b0;
    status           = ST_NONE;
    case (op_i)
      OP_START: begin
        if (running_q) begin
          status = ST_REJECTED;
        end else if (info_i.empty) begin
          status = ST_EMPTY;
        end else begin
          theta_sign_d     = info_i.theta_fwd;
          rho_sign_d       = info_i.rho_fwd;
          theta_total_d    = theta_mag_i;
          rho_total_d      = rho_mag_i;
          theta_left_d     = theta_mag_i;
          rho_left_d       = rho_mag_i;
          theta_major_d    = theta_mag_i >= rho_mag_i;
          error_d          = (theta_mag_i >= rho_mag_i) ?
                             $signed({3'b000, theta_mag_i[STEP_COUNT_BITS-1:1]}) :
                             -$signed({3'b000, rho_mag_i[STEP_COUNT_BITS-1:1]});
          interval_value_d = info_i.interval;
          interval_count_d = '0;
          elapsed_d        = '0;
          running_d        = 1'b1;
          status           = ST_ACCEPTED;
        end
      end
      OP_STOP: begin
        if (running_q) begin
          theta_total_d = '0;
          rho_total_d   = '0;
          theta_left_d  = '0;
          rho_left_d    = '0;
          error_d       = '0;
          running_d     = 1'b0;
          status        = ST_STOPPED;
        end
      end
      OP_TICK: begin
        if (running_q) begin
          if (elapsed_q != '1) begin
            elapsed_d = elapsed_q + TimeoutBits'(1);
          end
          interval_count_d = count_inc;
          if (alarm) begin
            interval_count_d = '0;
            if (theta_major_q) begin
              if (err_sub < 0) begin
                error_d = err_sub + theta_e;
                sr      = 1'b1;
              end else begin
                error_d = err_sub;
              end
              st = theta_left_q != '0;
            end else begin
              if (err_add > 0) begin
                error_d = err_add - rho_e;
                st      = 1'b1;
              end else begin
                error_d = err_add;
              end
              sr = rho_left_q != '0;
            end
            if (st && theta_left_q != '0) begin
              tp           = 1'b1;
              theta_left_d = theta_left_q - STEP_COUNT_BITS'(1);
              theta_pos_d  = theta_sign_q ? theta_pos_q + POSITION_BITS'(1) :
                                            theta_pos_q - POSITION_BITS'(1);
            end
            if (sr && rho_left_q != '0) begin
              rp         = 1'b1;
              rho_left_d = rho_left_q - STEP_COUNT_BITS'(1);
              rho_pos_d  = rho_sign_q ? rho_pos_q + POSITION_BITS'(1) :
                                        rho_pos_q - POSITION_BITS'(1);
            end
            if (theta_left_d == '0 && rho_left_d == '0) begin
              running_d = 1'b0;
              status    = ST_COMPLETE;
            end
          end
          if (running_d && elapsed_d >= timeout_ticks_i) begin
            theta_total_d = '0;
            rho_total_d   = '0;
            theta_left_d  = '0;
            rho_left_d    = '0;
            error_d       = '0;
            running_d     = 1'b0;
            status        = ST_TIMEOUT;
          end
        end
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_count_q <= '0;
      interval_value_q <= '0;
      elapsed_q        <= '0;
      theta_total_q    <= '0;
      rho_total_q      <= '0;
      theta_left_q     <= '0;
      rho_left_q       <= '0;
      error_q          <= '0;
      theta_major_q    <= 1'b1;
      theta_sign_q     <= 1'b1;
      rho_sign_q       <= 1'b1;
      running_q        <= 1'b0;
      theta_pos_q      <= '0;
      rho_pos_q        <= '0;
    end else if (fire_i) begin
      interval_count_q <= interval_count_d;
      interval_value_q <= interval_value_d;
      elapsed_q        <= elapsed_d;
      theta_total_q    <= theta_total_d;
      rho_total_q      <= rho_total_d;
      theta_left_q     <= theta_left_d;
      rho_left_q       <= rho_left_d;
      error_q          <= error_d;
      theta_major_q    <= theta_major_d;
      theta_sign_q     <= theta_sign_d;
      rho_sign_q       <= rho_sign_d;
      running_q        <= running_d;
      theta_pos_q      <= theta_pos_d;
      rho_pos_q        <= rho_pos_d;
    end
  end

  assign res_o.theta_pulse     = tp;
  assign res_o.rho_pulse       = rp;
  assign res_o.theta_direction = theta_sign_d;
  assign res_o.rho_direction   = rho_sign_d;
  assign res_o.theta_position  = PosOutBits'($signed(theta_pos_d));
  assign res_o.rho_position    = PosOutBits'($signed(rho_pos_d));
  assign res_o.busy_res        = running_d;
  assign res_o.status          = status;

  a_count_below_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> interval_count_q < interval_value_q)
    else $error("interval counter reached the interval while running");

  a_running_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (theta_left_q != '0 || rho_left_q != '0))
    else $error("move running with no steps left");

  a_pulse_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (tp || rp)) |-> running_q)
    else $error("step pulse while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && status == ST_ACCEPTED) |=> running_q)
    else $error("accepted move did not start");

endmodule

// ===== sv/two_axis_bresenham_stepper_top.sv =====
// Top level of the two-axis Bresenham stepper: input register, configuration
// registers, start decode, move core and result register.
// Depends on tabs_pkg, tabs_start and tabs_core.
//
//   Channel     Direction  Handshake                  Payload
//   s_axis      in         s_axis_tvalid/tready       tdata 72b, tuser 2b
//   m_axis      out        m_axis_tvalid/tready       tdata 72b
//   cfg         in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// One beat is taken every cycle unless the output stalls; a result passes through
// the input register and the result register, the only stages.
// The move state is updated when an item moves from the input register to the
// result register, so the update of one item is seen by the next.
// While the result register holds an untaken beat, the input register fills
// and then both sides stall until m_axis_tready returns.
// Reset clears the move, restores the register defaults and empties both stages.
module two_axis_bresenham_stepper_top
  import tabs_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef,
  parameter int unsigned POSITION_BITS   = PositionBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // theta_cnt[23:0], rho_cnt[47:24], step_interval[67:48], zero fill
  input  logic [71:0]            s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // theta_pulse[0], rho_pulse[1], theta_direction[2], rho_direction[3],
  // theta_position[35:4], rho_position[67:36], busy_res[68], status[71:69]
  output logic [71:0]            m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  logic [IntervalBits-1:0] min_interval_q, max_interval_q, default_interval_q;
  logic [TimeoutBits-1:0]  timeout_ticks_q;

  logic                    in_valid_q, in_valid_d;
  logic [1:0]              in_op_q;
  logic [StepInBits-1:0]   in_theta_q, in_rho_q;
  logic [IntervalBits-1:0] in_interval_q;
  logic                    out_valid_q, out_valid_d;
  result_t                 out_data_q;

  logic                       out_free, fire, s_fire;
  logic [STEP_COUNT_BITS-1:0] theta_mag, rho_mag;
  start_info_t                info;
  result_t                    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q     <= MinIntervalRst;
      max_interval_q     <= MaxIntervalRst;
      default_interval_q <= DefaultIntervalRst;
      timeout_ticks_q    <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_INTERVAL:     min_interval_q     <= cfg_data_i[IntervalBits-1:0];
        CFG_MAX_INTERVAL:     max_interval_q     <= cfg_data_i[IntervalBits-1:0];
        CFG_DEFAULT_INTERVAL: default_interval_q <= cfg_data_i[IntervalBits-1:0];
        CFG_TIMEOUT_TICKS:    timeout_ticks_q    <= cfg_data_i[TimeoutBits-1:0];
        default:              timeout_ticks_q    <= timeout_ticks_q;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q       <= s_axis_tuser;
      in_theta_q    <= s_axis_tdata[23:0];
      in_rho_q      <= s_axis_tdata[47:24];
      in_interval_q <= s_axis_tdata[67:48];
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  tabs_start #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_start (
    .theta_cnt_i       (in_theta_q),
    .rho_cnt_i         (in_rho_q),
    .step_interval_i   (in_interval_q),
    .min_interval_i    (min_interval_q),
    .max_interval_i    (max_interval_q),
    .default_interval_i(default_interval_q),
    .theta_mag_o       (theta_mag),
    .rho_mag_o         (rho_mag),
    .info_o            (info)
  );

  tabs_core #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .POSITION_BITS  (POSITION_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .op_i           (in_op_q),
    .theta_mag_i    (theta_mag),
    .rho_mag_i      (rho_mag),
    .info_i         (info),
    .timeout_ticks_i(timeout_ticks_q),
    .res_o          (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
